[rtl/core/hmp_pkg.sv]
package hmp_pkg;

    localparam int MAX_PATCHES_PER_ROW = 1024;
    localparam int MAX_LODS            = 8;
    localparam int MAX_PATCH_LOG2      = 10;
    localparam int UPPER_DEPTH         = MAX_PATCHES_PER_ROW + MAX_LODS;
    localparam int L0_DEPTH            = MAX_PATCHES_PER_ROW;
    localparam int FIELD_MAX           = MAX_PATCHES_PER_ROW * 4 + 1;

    localparam logic signed [15:0] HI_EMPTY = 16'sd32767;
    localparam logic signed [15:0] LO_EMPTY = -16'sd32767;
    localparam logic signed [15:0] LO_FLOOR = -16'sd32768;

    // register indexes
    localparam logic [2:0] REG_FIELD_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FIELD_HEIGHT = 3'd1;
    localparam logic [2:0] REG_PATCH_LOG2   = 3'd2;
    localparam logic [2:0] REG_LOD_COUNT    = 3'd3;
    localparam logic [2:0] REG_NO_DATA      = 3'd4;

    typedef struct packed {
        logic signed [15:0] hi;
        logic signed [15:0] lo;
    } mm_t;

    typedef struct packed {
        logic [2:0] level;
        logic [9:0] col;
        logic [9:0] row;
        mm_t        mm;
    } rec_t;

    localparam mm_t EMPTY0  = '{hi: LO_FLOOR, lo: HI_EMPTY};
    localparam mm_t EMPTYUP = '{hi: LO_EMPTY, lo: HI_EMPTY};

    function automatic mm_t mm_merge(mm_t a, mm_t b);
        mm_t r;
        r = a;
        if (b.lo < a.lo) r.lo = b.lo;
        if (b.hi > a.hi) r.hi = b.hi;
        return r;
    endfunction

endpackage

[rtl/core/hmp_sample_if.sv]
interface hmp_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink (input valid, input height_sample, output ready);
endinterface

[rtl/core/hmp_record_if.sv]
interface hmp_record_if;
    logic               valid;
    logic               ready;
    logic [2:0]         level;
    logic [9:0]         patch_col;
    logic [9:0]         patch_row;
    logic signed [15:0] min_height;
    logic signed [15:0] max_height;
    logic               last;

    modport source (output valid, output level, output patch_col, output patch_row,
                    output min_height, output max_height, output last, input ready);
    modport sink (input valid, input level, input patch_col, input patch_row,
                  input min_height, input max_height, input last, output ready);
endinterface

[rtl/core/hmp_ram.sv]
module hmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/core/heightfield_minmax_pyramid.sv]
// Channel     Dir  Payload
// sample_in   in   height_sample
// record_out  out  level, patch_col, patch_row, min_height, max_height, last
// cfg_*       in   write enable, register index, data
//
// A sample with no patch edge is taken by itself. A patch edge sample reads the level-0
// memory, then updates it; for each upper level touched, the upper memory is read, then
// merged and written back; then the record is closed, after a further read step when the
// chain stops at the top level or at the end of the upper store.
// Records leave through a one-deep output register; the sequencer holds while it is full and not being taken.
// The input is not ready while the sequencer is busy or a register is being written.
// rst_n clears position, carry and control and sets the registers to their defaults; memories are not cleared.
module heightfield_minmax_pyramid (
    input  logic        clk,
    input  logic        rst_n,
    hmp_sample_if.sink  sample_in,
    hmp_record_if.source record_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import hmp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_L0, S_UP_RD, S_UP_MOD, S_FIN} state_t;

    state_t state_reg;

    logic [12:0] fw_reg, fh_reg;
    logic [3:0]  k_raw_reg, lods_raw_reg;
    logic signed [15:0] nodata_reg;

    logic [12:0] x_reg, y_reg;
    mm_t         carry_reg, single_reg, tot_reg;
    logic [9:0]  c_reg, cx_reg, cz_reg;
    logic        rowend_reg, ygt0_reg;
    logic [10:0] pw_reg, ph_reg, off_reg, idx_reg;
    logic [3:0]  lvl_reg;
    logic        first_reg, lastc_reg;
    rec_t        pend_reg, out_reg;
    logic        out_valid_reg;
    logic        out_last_reg;

    // clamped configuration
    logic [12:0] w_c, h_c, p_mask;
    logic [3:0]  k_c, lods_c;
    always_comb
    begin
        w_c = (fw_reg < 13'd2) ? 13'd2 : (fw_reg > 13'(FIELD_MAX)) ? 13'(FIELD_MAX) : fw_reg;
        h_c = (fh_reg < 13'd2) ? 13'd2 : (fh_reg > 13'(FIELD_MAX)) ? 13'(FIELD_MAX) : fh_reg;
        k_c = (k_raw_reg < 4'd2) ? 4'd2 :
              (k_raw_reg > 4'(MAX_PATCH_LOG2)) ? 4'(MAX_PATCH_LOG2) : k_raw_reg;
        lods_c = (lods_raw_reg < 4'd1) ? 4'd1 :
                 (lods_raw_reg > 4'(MAX_LODS)) ? 4'(MAX_LODS) : lods_raw_reg;
        p_mask = (13'd1 << k_c) - 13'd1;
    end

    // sample path
    logic        accept, smp_valid, edge_hit, row_hit;
    mm_t         single_c, carry_c;
    logic [12:0] xm1, ym1;
    logic [12:0] pw_full, ph_full;
    always_comb
    begin
        accept    = sample_in.valid && sample_in.ready;
        smp_valid = sample_in.height_sample != nodata_reg;
        single_c  = EMPTY0;
        if (smp_valid)
        begin
            single_c.hi = sample_in.height_sample;
            single_c.lo = sample_in.height_sample;
        end
        carry_c   = mm_merge((x_reg == 13'd0) ? EMPTY0 : carry_reg, single_c);
        edge_hit  = (x_reg != 13'd0) && (((x_reg & p_mask) == 13'd0) || (x_reg == w_c - 13'd1));
        row_hit   = (y_reg != 13'd0) && (((y_reg & p_mask) == 13'd0) || (y_reg == h_c - 13'd1));
        xm1       = x_reg - 13'd1;
        ym1       = y_reg - 13'd1;
        pw_full   = (w_c - 13'd1 + p_mask) >> k_c;
        ph_full   = (h_c - 13'd1 + p_mask) >> k_c;
    end

    // level-0 update
    logic [31:0] rd0, rdu;
    mm_t         tot_c, tot_fix;
    always_comb
    begin
        tot_c   = ygt0_reg ? mm_merge(mm_t'(rd0), carry_reg) : carry_reg;
        tot_fix = tot_c;
        if (tot_c.lo == HI_EMPTY && tot_c.hi == LO_FLOOR)
        begin
            tot_fix.hi = LO_EMPTY;
        end
    end

    // upper level control
    logic [11:0] idx_sum;
    logic        first_c, lastc_c;
    logic [10:0] npw, nph;
    mm_t         acc_c;
    logic        out_free, out_load;
    always_comb
    begin
        idx_sum  = {1'b0, off_reg} + 12'(cx_reg >> 1);
        first_c  = !cx_reg[0] && !cz_reg[0];
        lastc_c  = (cx_reg[0] || ({1'b0, cx_reg} == pw_reg - 11'd1)) &&
                   (cz_reg[0] || ({1'b0, cz_reg} == ph_reg - 11'd1));
        npw      = (pw_reg + 11'd1) >> 1;
        nph      = (ph_reg + 11'd1) >> 1;
        acc_c    = mm_merge(first_reg ? EMPTYUP : mm_t'(rdu), tot_reg);
        out_free = !out_valid_reg || record_out.ready;
        out_load = !cfg_we && out_free &&
                   ((state_reg == S_UP_MOD && lastc_reg) || (state_reg == S_FIN));
    end

    logic we0, re0, weu, reu;
    always_comb
    begin
        re0 = (state_reg == S_IDLE) && accept && edge_hit;
        we0 = (state_reg == S_L0);
        reu = (state_reg == S_UP_RD) && (lvl_reg < lods_c) &&
              (idx_sum < 12'(UPPER_DEPTH)) && !first_c;
        weu = (state_reg == S_UP_MOD);
    end

    hmp_ram #(.WIDTH(32), .DEPTH(L0_DEPTH)) u_l0_ram (
        .clk   (clk),
        .we    (we0),
        .waddr (c_reg),
        .wdata (rowend_reg ? 32'(carry_reg) : 32'(tot_c)),
        .re    (re0),
        .raddr (10'(xm1 >> k_c)),
        .rdata (rd0)
    );

    hmp_ram #(.WIDTH(32), .DEPTH(UPPER_DEPTH)) u_up_ram (
        .clk   (clk),
        .we    (weu),
        .waddr (idx_reg),
        .wdata (32'(acc_c)),
        .re    (reu),
        .raddr (idx_sum[10:0]),
        .rdata (rdu)
    );

    assign sample_in.ready       = (state_reg == S_IDLE) && !cfg_we;
    assign record_out.valid      = out_valid_reg;
    assign record_out.level      = out_reg.level;
    assign record_out.patch_col  = out_reg.col;
    assign record_out.patch_row  = out_reg.row;
    assign record_out.min_height = out_reg.mm.lo;
    assign record_out.max_height = out_reg.mm.hi;
    assign record_out.last       = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fw_reg        <= 13'd1025;
            fh_reg        <= 13'd1025;
            k_raw_reg     <= 4'd5;
            lods_raw_reg  <= 4'd4;
            nodata_reg    <= LO_FLOOR;
            x_reg         <= '0;
            y_reg         <= '0;
            carry_reg     <= EMPTY0;
            single_reg    <= EMPTY0;
            tot_reg       <= EMPTY0;
            c_reg         <= '0;
            cx_reg        <= '0;
            cz_reg        <= '0;
            rowend_reg    <= 1'b0;
            ygt0_reg      <= 1'b0;
            pw_reg        <= '0;
            ph_reg        <= '0;
            off_reg       <= '0;
            idx_reg       <= '0;
            lvl_reg       <= '0;
            first_reg     <= 1'b0;
            lastc_reg     <= 1'b0;
            pend_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && record_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FIELD_WIDTH:  fw_reg       <= cfg_data[12:0];
                    REG_FIELD_HEIGHT: fh_reg       <= cfg_data[12:0];
                    REG_PATCH_LOG2:   k_raw_reg    <= cfg_data[3:0];
                    REG_LOD_COUNT:    lods_raw_reg <= cfg_data[3:0];
                    REG_NO_DATA:      nodata_reg   <= cfg_data;
                    default: ;
                endcase
                if (cfg_index <= REG_NO_DATA)
                begin
                    x_reg     <= '0;
                    y_reg     <= '0;
                    carry_reg <= EMPTY0;
                end
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (accept)
                        begin
                            carry_reg  <= carry_c;
                            single_reg <= single_c;
                            c_reg      <= 10'(xm1 >> k_c);
                            cz_reg     <= 10'(ym1 >> k_c);
                            rowend_reg <= row_hit;
                            ygt0_reg   <= (y_reg != 13'd0);
                            pw_reg     <= pw_full[10:0];
                            ph_reg     <= ph_full[10:0];
                            if (x_reg + 13'd1 >= w_c)
                            begin
                                x_reg <= '0;
                                y_reg <= (y_reg + 13'd1 >= h_c) ? 13'd0 : y_reg + 13'd1;
                            end
                            else
                            begin
                                x_reg <= x_reg + 13'd1;
                            end
                            if (edge_hit)
                            begin
                                state_reg <= S_L0;
                            end
                        end
                    end
                    S_L0:
                    begin
                        carry_reg <= single_reg;
                        if (rowend_reg)
                        begin
                            tot_reg   <= tot_fix;
                            pend_reg  <= '{level: 3'd0, col: c_reg, row: cz_reg, mm: tot_fix};
                            cx_reg    <= c_reg;
                            off_reg   <= '0;
                            lvl_reg   <= 4'd1;
                            state_reg <= S_UP_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_UP_RD:
                    begin
                        idx_reg   <= idx_sum[10:0];
                        first_reg <= first_c;
                        lastc_reg <= lastc_c;
                        if (lvl_reg >= lods_c || idx_sum >= 12'(UPPER_DEPTH))
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_UP_MOD;
                        end
                    end
                    S_UP_MOD:
                    begin
                        if (!lastc_reg)
                        begin
                            state_reg <= S_FIN;
                        end
                        else if (out_free)
                        begin
                            // earlier record is known not to be the final one
                            out_reg       <= pend_reg;
                            out_last_reg  <= 1'b0;
                            pend_reg      <= '{level: lvl_reg[2:0], col: cx_reg >> 1,
                                               row: cz_reg >> 1, mm: acc_c};
                            tot_reg       <= acc_c;
                            cx_reg        <= cx_reg >> 1;
                            cz_reg        <= cz_reg >> 1;
                            off_reg       <= off_reg + npw;
                            pw_reg        <= npw;
                            ph_reg        <= nph;
                            lvl_reg       <= lvl_reg + 4'd1;
                            state_reg     <= S_UP_RD;
                        end
                    end
                    S_FIN:
                    begin
                        if (out_free)
                        begin
                            out_reg       <= pend_reg;
                            out_last_reg  <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end
endmodule
